@@ rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape unit: result kinds,
// error codes and the command that travels from the decoder to the emitter.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int JSU_QUEUE_DEPTH = 4;

	// result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
	localparam logic [2:0] ERR_UNTERM    = 3'd2;
	localparam logic [2:0] ERR_UNTERM_ES = 3'd3;
	localparam logic [2:0] ERR_UNK_ESC   = 3'd4;
	localparam logic [2:0] ERR_TRUNC_HEX = 3'd5;
	localparam logic [2:0] ERR_BAD_HEX   = 3'd6;

	localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;

	// results of one input: code point a, then code point b, then a tail
	// raw marks a document byte that goes out as is, without UTF-8 encoding
	typedef struct packed {
		logic        a_v;
		logic        a_raw;
		logic [20:0] a_cp;
		logic        b_v;
		logic        b_raw;
		logic [15:0] b_cp;
		logic        t_v;
		logic [1:0]  t_kind;
		logic [2:0]  t_code;
	} cmd_t;

endpackage

@@ rtl/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Byte classifier and escape decoder. Tracks the string state and turns each
// accepted byte that causes results into one command describing all of them.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       at_end,
	output logic       cmd_v,
	output cmd_t       cmd
);

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_STR     = 3'd1;
	localparam logic [2:0] M_ESC     = 3'd2;
	localparam logic [2:0] M_HEX     = 3'd3;
	localparam logic [2:0] M_HIGH    = 3'd4;
	localparam logic [2:0] M_HIGH_BS = 3'd5;
	localparam logic [2:0] M_LOW_HEX = 3'd6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [11:0] hex_accum_q, hex_accum_d;
	logic [9:0]  held_high_q, held_high_d;

	logic [4:0]  hex_dig;
	logic [8:0]  esc_dec;
	logic [15:0] v16;
	logic        v_high, v_low;

	// {valid, digit}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// {valid, decoded byte} for the simple escapes
	function automatic logic [8:0] esc_simple(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h22: r = {1'b1, 8'h22};
			8'h5C: r = {1'b1, 8'h5C};
			8'h2F: r = {1'b1, 8'h2F};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	assign hex_dig = hex_digit(in_byte);
	assign esc_dec = esc_simple(in_byte);
	assign v16     = {hex_accum_q, hex_dig[3:0]};
	assign v_high  = (v16[15:10] == 6'b110110);
	assign v_low   = (v16[15:10] == 6'b110111);

	always_comb begin
		cmd         = '0;
		mode_d      = mode_q;
		hex_count_d = hex_count_q;
		hex_accum_d = hex_accum_q;
		held_high_d = held_high_q;
		case (mode_q)
			M_IDLE: begin
				if (at_end || in_byte != CH_QUOTE) begin
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = ERR_NO_QUOTE;
				end else begin
					mode_d = M_STR;
				end
			end
			M_STR: begin
				if (at_end) begin
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = ERR_UNTERM;
					mode_d     = M_IDLE;
				end else if (in_byte == CH_QUOTE) begin
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_CLOSE;
					mode_d     = M_IDLE;
				end else if (in_byte == CH_BSL) begin
					mode_d = M_ESC;
				end else begin
					cmd.a_v   = 1'b1;
					cmd.a_raw = 1'b1;
					cmd.a_cp  = 21'(in_byte);
				end
			end
			M_ESC: begin
				if (at_end) begin
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = ERR_UNTERM_ES;
					mode_d     = M_IDLE;
				end else if (esc_dec[8]) begin
					cmd.a_v  = 1'b1;
					cmd.a_cp = 21'(esc_dec[7:0]);
					mode_d   = M_STR;
				end else if (in_byte == CH_U) begin
					mode_d      = M_HEX;
					hex_count_d = 2'd0;
					hex_accum_d = '0;
				end else begin
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = ERR_UNK_ESC;
					mode_d     = M_IDLE;
				end
			end
			M_HEX: begin
				if (at_end || !hex_dig[4]) begin
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = at_end ? ERR_TRUNC_HEX : ERR_BAD_HEX;
					mode_d     = M_IDLE;
				end else if (hex_count_q != 2'd3) begin
					hex_accum_d = v16[11:0];
					hex_count_d = hex_count_q + 2'd1;
				end else begin
					hex_count_d = 2'd0;
					hex_accum_d = '0;
					if (v_high) begin
						held_high_d = v16[9:0];
						mode_d      = M_HIGH;
					end else begin
						cmd.a_v  = 1'b1;
						cmd.a_cp = 21'(v_low ? CP_REPLACEMENT : v16);
						mode_d   = M_STR;
					end
				end
			end
			M_HIGH: begin
				if (at_end) begin
					cmd.a_v    = 1'b1;
					cmd.a_cp   = 21'(CP_REPLACEMENT);
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = ERR_UNTERM;
					mode_d     = M_IDLE;
				end else if (in_byte == CH_BSL) begin
					mode_d = M_HIGH_BS;
				end else begin
					// replacement, then the byte as a string byte
					cmd.a_v  = 1'b1;
					cmd.a_cp = 21'(CP_REPLACEMENT);
					mode_d   = M_STR;
					if (in_byte == CH_QUOTE) begin
						cmd.t_v    = 1'b1;
						cmd.t_kind = KIND_CLOSE;
						mode_d     = M_IDLE;
					end else begin
						cmd.b_v   = 1'b1;
						cmd.b_raw = 1'b1;
						cmd.b_cp  = 16'(in_byte);
					end
				end
			end
			M_HIGH_BS: begin
				if (at_end) begin
					cmd.a_v    = 1'b1;
					cmd.a_cp   = 21'(CP_REPLACEMENT);
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = ERR_UNTERM_ES;
					mode_d     = M_IDLE;
				end else if (in_byte == CH_U) begin
					mode_d      = M_LOW_HEX;
					hex_count_d = 2'd0;
					hex_accum_d = '0;
				end else begin
					cmd.a_v  = 1'b1;
					cmd.a_cp = 21'(CP_REPLACEMENT);
					// the byte is taken as an escape character, 'u' cannot occur here
					if (esc_dec[8]) begin
						cmd.b_v  = 1'b1;
						cmd.b_cp = 16'(esc_dec[7:0]);
						mode_d   = M_STR;
					end else begin
						cmd.t_v    = 1'b1;
						cmd.t_kind = KIND_ERROR;
						cmd.t_code = ERR_UNK_ESC;
						mode_d     = M_IDLE;
					end
				end
			end
			M_LOW_HEX: begin
				if (at_end || !hex_dig[4]) begin
					cmd.t_v    = 1'b1;
					cmd.t_kind = KIND_ERROR;
					cmd.t_code = at_end ? ERR_TRUNC_HEX : ERR_BAD_HEX;
					mode_d     = M_IDLE;
				end else if (hex_count_q != 2'd3) begin
					hex_accum_d = v16[11:0];
					hex_count_d = hex_count_q + 2'd1;
				end else begin
					hex_count_d = 2'd0;
					hex_accum_d = '0;
					cmd.a_v     = 1'b1;
					if (v_low) begin
						cmd.a_cp    = 21'h10000 + 21'({held_high_q, v16[9:0]});
						held_high_d = '0;
						mode_d      = M_STR;
					end else begin
						// unpaired high, then the new value on its own, or held if it is a high
						cmd.a_cp = 21'(CP_REPLACEMENT);
						mode_d   = M_STR;
						if (v_high) begin
							held_high_d = v16[9:0];
							mode_d      = M_HIGH;
						end else begin
							held_high_d = '0;
							cmd.b_v     = 1'b1;
							cmd.b_cp    = v_low ? CP_REPLACEMENT : v16;
						end
					end
				end
			end
			default: begin
				mode_d      = M_IDLE;
				hex_count_d = 2'd0;
				hex_accum_d = '0;
				held_high_d = '0;
			end
		endcase
		if (mode_d == M_IDLE) begin
			hex_count_d = 2'd0;
			hex_accum_d = '0;
			held_high_d = '0;
		end
	end

	assign cmd_v = accept && (cmd.a_v || cmd.b_v || cmd.t_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			hex_count_q <= 2'd0;
			hex_accum_q <= '0;
			held_high_q <= '0;
		end else if (accept) begin
			mode_q      <= mode_d;
			hex_count_q <= hex_count_d;
			hex_accum_q <= hex_accum_d;
			held_high_q <= held_high_d;
		end
	end

endmodule

@@ rtl/jsu_queue.sv @@
// ----------------------------------------------------------------------------
// jsu_queue
// Small command queue between the decoder and the byte emitter.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = JSU_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// Result emitter. Walks one command at a time, one result per cycle while
// results are popped: UTF-8 bytes of the first code point, of the second,
// then the close or error.
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       q_dout,
	input  logic       q_empty,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic [2:0] error_code,
	output logic       last
);

	localparam logic [1:0] SEG_A = 2'd0;
	localparam logic [1:0] SEG_B = 2'd1;
	localparam logic [1:0] SEG_T = 2'd2;

	cmd_t        cur_q;
	logic        cur_v_q;
	logic [1:0]  seg_q;
	logic [1:0]  idx_q;

	logic        out_v_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_byte_q;
	logic [2:0]  error_code_q;
	logic        last_q;

	logic [20:0] seg_cp;
	logic        seg_raw;
	logic [1:0]  len_m1;
	logic        seg_end, more, cur_last, advance;
	logic [1:0]  kind_d;
	logic [7:0]  byte_d;
	logic [2:0]  code_d;

	// encoded length minus one
	function automatic logic [1:0] utf8_len(input logic [20:0] cp);
		logic [1:0] r;
		if (cp < 21'h80)
			r = 2'd0;
		else if (cp < 21'h800)
			r = 2'd1;
		else if (cp < 21'h10000)
			r = 2'd2;
		else
			r = 2'd3;
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] lm1,
		input logic [1:0] idx);
		logic [7:0] r;
		logic [1:0] from_end;
		from_end = lm1 - idx;
		if (idx == 2'd0) begin
			case (lm1)
				2'd0: r = cp[7:0];
				2'd1: r = 8'hC0 | {3'd0, cp[10:6]};
				2'd2: r = 8'hE0 | {4'd0, cp[15:12]};
				default: r = 8'hF0 | {5'd0, cp[20:18]};
			endcase
		end else begin
			case (from_end)
				2'd0: r = 8'h80 | {2'd0, cp[5:0]};
				2'd1: r = 8'h80 | {2'd0, cp[11:6]};
				default: r = 8'h80 | {2'd0, cp[17:12]};
			endcase
		end
		return r;
	endfunction

	always_comb begin
		seg_cp  = (seg_q == SEG_A) ? cur_q.a_cp : 21'(cur_q.b_cp);
		seg_raw = (seg_q == SEG_A) ? cur_q.a_raw : cur_q.b_raw;
		// raw document bytes go out as a single byte
		len_m1  = seg_raw ? 2'd0 : utf8_len(seg_cp);
		kind_d  = KIND_BYTE;
		byte_d  = '0;
		code_d  = ERR_NONE;
		case (seg_q)
			SEG_A: begin
				seg_end = (idx_q == len_m1);
				more    = cur_q.b_v || cur_q.t_v;
				byte_d  = utf8_byte(seg_cp, len_m1, idx_q);
			end
			SEG_B: begin
				seg_end = (idx_q == len_m1);
				more    = cur_q.t_v;
				byte_d  = utf8_byte(seg_cp, len_m1, idx_q);
			end
			default: begin
				seg_end = 1'b1;
				more    = 1'b0;
				kind_d  = cur_q.t_kind;
				code_d  = (cur_q.t_kind == KIND_ERROR) ? cur_q.t_code : ERR_NONE;
			end
		endcase
	end

	assign cur_last = seg_end && !more;
	assign advance  = cur_v_q && (!out_v_q || pop);
	assign q_pop    = !q_empty && (!cur_v_q || (advance && cur_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			seg_q   <= SEG_A;
			idx_q   <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_v_q <= 1'b1;
				seg_q   <= q_dout.a_v ? SEG_A : (q_dout.b_v ? SEG_B : SEG_T);
				idx_q   <= 2'd0;
			end else if (advance) begin
				if (cur_last) begin
					cur_v_q <= 1'b0;
				end else if (seg_end) begin
					seg_q <= (seg_q == SEG_A && cur_q.b_v) ? SEG_B : SEG_T;
					idx_q <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (advance)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_dout;
		if (advance) begin
			out_kind_q   <= kind_d;
			out_byte_q   <= byte_d;
			error_code_q <= code_d;
			last_q       <= cur_last;
		end
	end

	assign empty      = !out_v_q;
	assign out_kind   = out_kind_q;
	assign out_byte   = out_byte_q;
	assign error_code = error_code_q;
	assign last       = last_q;

endmodule

@@ rtl/json_string_unescape_utf8_unit.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string unescaper with UTF-8 output: decoder front, command queue,
// byte emitter back.
//
//   channel   handshake            payload
//   input     push / full          in_byte, at_end
//   result    empty / pop          out_kind, out_byte, error_code, last
//
// one input byte is accepted per cycle while the command queue has room;
// the emitter delivers one result per cycle while results are popped, so the
// bytes of a multi-byte UTF-8 sequence (up to six results per input) back up and the queue absorbs them.
// a result passes the queue, the command register and the output register.
// reset clears the decoder to idle and empties the queue and output register.
// full rises when the queue holds QUEUE_DEPTH commands; a stalled pop backs
// up through the output register into the queue.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       at_end,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic [2:0] error_code,
	output logic       last
);

	logic accept;
	logic cmd_v;
	cmd_t cmd;
	cmd_t q_dout;
	logic q_empty, q_full, q_pop;

	assign full   = q_full;
	assign accept = push && !q_full;

	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.at_end  (at_end),
		.cmd_v   (cmd_v),
		.cmd     (cmd)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_v),
		.din    (cmd),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.full   (q_full)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_dout     (q_dout),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last)
	);

endmodule

@@ rtl/jsu_checker.sv @@
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result channel of the unescape unit.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic [2:0] error_code,
	input logic       last
);

	// a waiting result holds still until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_kind) && $stable(out_byte)
			&& $stable(error_code) && $stable(last))
		else $error("result changed while stalled");

	// close and error always end the results of an input
	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (out_kind == KIND_CLOSE || out_kind == KIND_ERROR) |-> last)
		else $error("close or error not marked last");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_kind != KIND_ERROR |-> error_code == ERR_NONE)
		else $error("error code set on a non-error result");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_kind != KIND_BYTE |-> out_byte == 8'd0)
		else $error("byte set on a close or error result");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.out_kind   (out_kind),
	.out_byte   (out_byte),
	.error_code (error_code),
	.last       (last)
);
